// ===== rtl/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and constants for the dimmed HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    // Pipeline depth, input register to output register
    localparam int unsigned NUM_STAGES = 6;

    // Largest channel level, and the number of hue sectors
    localparam logic [7:0]  CH_MAX       = 8'd255;
    localparam logic [18:0] SECTORS      = 19'd6;

    // Reciprocal of 255 for 16-bit dividends: x/255 = (x * DIV255_MAGIC) >> DIV255_SHIFT
    localparam logic [15:0] DIV255_MAGIC = 16'h8081;
    localparam int unsigned DIV255_SHIFT = 23;

    // Brightness register
    localparam int unsigned BRIGHT_W     = 9;
    localparam logic [BRIGHT_W-1:0] FULL_BRIGHTNESS = 9'd256;

    // Hue sector, one sixth of a turn each
    typedef enum logic [2:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } sector_t;

endpackage

// ===== rtl/hsv_to_rgb_dimmed.sv =====
// An accepted request passes through all six register stages to its result on the m_ side.
// Throughput: one request per cycle while m_ready is high; set by the six-stage register pipeline.
// A stalled output holds its result; empty stages still take new requests.
// Reset (aresetn low, synchronous) empties the pipeline and sets brightness
// to 256 (full).
// ----------------------------------------------------------------------------
// hsv_to_rgb_dimmed
// Six-sector HSV to RGB conversion in exact fixed point, with PWM duties
// scaled by a programmable brightness register.
// ----------------------------------------------------------------------------
module hsv_to_rgb_dimmed
    import hsvrgb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    // Brightness register write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BRIGHT_W-1:0] cfg_data,

    // Colour in
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [15:0]         s_hue,
    input  logic [7:0]          s_saturation,
    input  logic [7:0]          s_brightness_value,

    // Colour out
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_red_raw,
    output logic [7:0]          m_green_raw,
    output logic [7:0]          m_blue_raw,
    output logic [7:0]          m_red_duty,
    output logic [7:0]          m_green_duty,
    output logic [7:0]          m_blue_duty
);

    // ------------------------------------------------------------------
    // Brightness register, clamped to full scale on write
    // ------------------------------------------------------------------
    logic [BRIGHT_W-1:0] bright_reg;
    logic [BRIGHT_W-1:0] bright_next;

    assign cfg_ready   = 1'b1;
    assign bright_next = (cfg_data > FULL_BRIGHTNESS) ? FULL_BRIGHTNESS : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= FULL_BRIGHTNESS;
        end else if (cfg_valid && cfg_ready) begin
            bright_reg <= bright_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and per-stage load enables (bubbles collapse on stall)
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   rdy;

    always_comb begin
        rdy[NUM_STAGES] = m_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hue * 6 gives sector and fraction; v * s
    // ------------------------------------------------------------------
    logic [18:0] h6_next;
    logic [15:0] vs1_next;
    logic [2:0]  sec1_reg;
    logic [15:0] frac1_reg;
    logic [15:0] vs1_reg;
    logic [7:0]  v1_reg;

    assign h6_next  = {3'b000, s_hue} * SECTORS;
    assign vs1_next = {8'h00, s_brightness_value} * {8'h00, s_saturation};

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            sec1_reg  <= h6_next[18:16];
            frac1_reg <= h6_next[15:0];
            vs1_reg   <= vs1_next;
            v1_reg    <= s_brightness_value;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: a = v*s*f; v*255 and v*(255-s)
    // ------------------------------------------------------------------
    logic [31:0] a2_next;
    logic [15:0] v255_2_next;
    logic [15:0] pnum2_next;
    logic [2:0]  sec2_reg;
    logic [31:0] a2_reg;
    logic [15:0] v255_2_reg;
    logic [15:0] pnum2_reg;

    assign a2_next     = {16'h0000, vs1_reg} * {16'h0000, frac1_reg};
    assign v255_2_next = {8'h00, v1_reg} * {8'h00, CH_MAX};
    assign pnum2_next  = v255_2_next - vs1_reg;

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            sec2_reg   <= sec1_reg;
            a2_reg     <= a2_next;
            v255_2_reg <= v255_2_next;
            pnum2_reg  <= pnum2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: numerators over 255
    //   q: v*255 - ceil(a / 2^16)
    //   t: v*(255-s) + floor(a / 2^16)
    // ------------------------------------------------------------------
    logic [15:0] a_ceil3;
    logic [15:0] qnum3_next;
    logic [15:0] tnum3_next;
    logic [2:0]  sec3_reg;
    logic [15:0] pnum3_reg;
    logic [15:0] qnum3_reg;
    logic [15:0] tnum3_reg;

    assign a_ceil3    = a2_reg[31:16] + {15'd0, (a2_reg[15:0] != 16'h0000)};
    assign qnum3_next = v255_2_reg - a_ceil3;
    assign tnum3_next = pnum2_reg + a2_reg[31:16];

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            sec3_reg  <= sec2_reg;
            pnum3_reg <= pnum2_reg;
            qnum3_reg <= qnum3_next;
            tnum3_reg <= tnum3_next;
        end
    end

    // v delayed alongside stages 2 and 3
    logic [7:0] v2_reg;
    logic [7:0] v3_reg;

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            v2_reg <= v1_reg;
        end
        if (rdy[2]) begin
            v3_reg <= v2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: divide by 255 through the reciprocal (exact for 16 bits)
    // ------------------------------------------------------------------
    logic [31:0] pprod4;
    logic [31:0] qprod4;
    logic [31:0] tprod4;
    logic [2:0]  sec4_reg;
    logic [7:0]  v4_reg;
    logic [7:0]  p4_reg;
    logic [7:0]  q4_reg;
    logic [7:0]  t4_reg;
    logic [7:0]  v4_next;

    assign pprod4  = {16'h0000, pnum3_reg} * {16'h0000, DIV255_MAGIC};
    assign qprod4  = {16'h0000, qnum3_reg} * {16'h0000, DIV255_MAGIC};
    assign tprod4  = {16'h0000, tnum3_reg} * {16'h0000, DIV255_MAGIC};
    // v itself needs no division, taken from its delay line
    assign v4_next = v3_reg;

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            sec4_reg <= sec3_reg;
            v4_reg   <= v4_next;
            p4_reg   <= pprod4[DIV255_SHIFT+7:DIV255_SHIFT];
            q4_reg   <= qprod4[DIV255_SHIFT+7:DIV255_SHIFT];
            t4_reg   <= tprod4[DIV255_SHIFT+7:DIV255_SHIFT];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: sector selects the channel mapping
    // ------------------------------------------------------------------
    logic [7:0] r5_next;
    logic [7:0] g5_next;
    logic [7:0] b5_next;
    logic [7:0] r5_reg;
    logic [7:0] g5_reg;
    logic [7:0] b5_reg;

    always_comb begin
        case (sector_t'(sec4_reg))
            SEC_RED_YELLOW: begin
                r5_next = v4_reg; g5_next = t4_reg; b5_next = p4_reg;
            end
            SEC_YELLOW_GREEN: begin
                r5_next = q4_reg; g5_next = v4_reg; b5_next = p4_reg;
            end
            SEC_GREEN_CYAN: begin
                r5_next = p4_reg; g5_next = v4_reg; b5_next = t4_reg;
            end
            SEC_CYAN_BLUE: begin
                r5_next = p4_reg; g5_next = q4_reg; b5_next = v4_reg;
            end
            SEC_BLUE_MAGENTA: begin
                r5_next = t4_reg; g5_next = p4_reg; b5_next = v4_reg;
            end
            default: begin
                r5_next = v4_reg; g5_next = p4_reg; b5_next = q4_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            r5_reg <= r5_next;
            g5_reg <= g5_next;
            b5_reg <= b5_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: brightness scaling, duty = raw*brightness/256; output register
    // ------------------------------------------------------------------
    logic [16:0] rdim6;
    logic [16:0] gdim6;
    logic [16:0] bdim6;
    logic [7:0]  rraw_reg;
    logic [7:0]  graw_reg;
    logic [7:0]  braw_reg;
    logic [7:0]  rduty_reg;
    logic [7:0]  gduty_reg;
    logic [7:0]  bduty_reg;

    assign rdim6 = {9'd0, r5_reg} * {8'd0, bright_reg};
    assign gdim6 = {9'd0, g5_reg} * {8'd0, bright_reg};
    assign bdim6 = {9'd0, b5_reg} * {8'd0, bright_reg};

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            rraw_reg  <= r5_reg;
            graw_reg  <= g5_reg;
            braw_reg  <= b5_reg;
            rduty_reg <= rdim6[15:8];
            gduty_reg <= gdim6[15:8];
            bduty_reg <= bdim6[15:8];
        end
    end

    assign m_red_raw    = rraw_reg;
    assign m_green_raw  = graw_reg;
    assign m_blue_raw   = braw_reg;
    assign m_red_duty   = rduty_reg;
    assign m_green_duty = gduty_reg;
    assign m_blue_duty  = bduty_reg;

endmodule
